@@ hw/rtl/idsc_pkg.sv @@
// Shared constants and the quarter-wave sine function for the degree sine/cosine block.
package idsc_pkg;

  localparam int ANGLE_W      = 16;
  localparam int VALUE_W      = 15;
  localparam int MAG_W        = 14;
  localparam int FOLD_W       = 7;
  localparam int REM_W        = 9;
  localparam int QUOT_W       = 7;

  localparam int FULL_TURN    = 360;
  localparam int HALF_TURN    = 180;
  localparam int QUARTER_TURN = 90;
  localparam int OCTANT       = 45;
  localparam int MAX_VALUE    = 9999;

  // floor(2^17 / 45); with the angle pre-shifted by three this estimates angle / 360.
  localparam int RECIP_45     = 2912;
  localparam int RECIP_SHIFT  = 17;

  localparam longint LOW_DIV  = 10000;
  localparam longint HIGH_DIV = 100000;

  // Sine of a folded angle 0..90 in ten-thousandths, from the two cubic fits.
  // Called only with constant arguments, so each call reduces to a constant.
  function automatic logic [MAG_W-1:0] sine_q(input int x);
    longint xl;
    longint acc;
    xl = longint'(x);
    if (x <= OCTANT) begin
      acc = -64'sd81;
      acc = acc * xl - 64'sd277;
      acc = acc * xl + 64'sd1747900;
      acc = acc * xl - 64'sd1600;
      acc = acc / LOW_DIV;
    end else begin
      xl  = longint'(QUARTER_TURN) - xl;
      acc = 64'sd336;
      acc = acc * xl - 64'sd161420;
      acc = acc * xl + 64'sd75484;
      acc = acc * xl + 64'sd999960000;
      acc = acc / HIGH_DIV;
    end
    return acc[MAG_W-1:0];
  endfunction

endpackage

@@ hw/rtl/integer_degree_sine_cosine.sv @@
// Top level of the pipelined integer-degree sine and cosine unit.
//
// Usage:
//   The input channel carries command (0 sine, 1 cosine) and a signed angle in
//   whole degrees. The output channel carries trig_value, the result scaled by
//   10000 as a signed number in -9999..9999. Both channels use valid and stall;
//   a beat moves on a rising edge where valid is high and stall is low.
//   Throughput is one beat per cycle while no stall holds the pipeline: five
//   register stages (offset and magnitude, reciprocal quotient, remainder,
//   quadrant fold, table lookup and sign) each pass one item per cycle.
//   When the receiver stalls while an output beat is waiting, the whole
//   pipeline holds and in_stall rises in the same cycle; nothing is dropped
//   or repeated, and the held output does not change.
//   Synchronous reset clears every stage valid bit; the block keeps no other
//   state and is ready for input in the first cycle after reset.
module integer_degree_sine_cosine
  import idsc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      command,
  input  logic signed [ANGLE_W-1:0] angle_degrees,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] trig_value
);

  localparam int SUM_W  = ANGLE_W + 2;
  localparam int PROD_W = ANGLE_W - 3 + 12;

  logic advance;

  // Stage 1: cosine offset, then magnitude and input sign.
  logic                    v1;
  logic                    neg1;
  logic [ANGLE_W-1:0]      mag1;
  logic signed [SUM_W-1:0] sum_c;
  logic [SUM_W-1:0]        abs_c;

  // Stage 2: quotient estimate of magnitude / 360.
  logic                v2;
  logic                neg2;
  logic [ANGLE_W-1:0]  mag2;
  logic [QUOT_W-1:0]   q2;
  logic [PROD_W-1:0]   prod_c;

  // Stage 3: remainder modulo 360.
  logic                v3;
  logic                neg3;
  logic [REM_W-1:0]    r3;
  logic [ANGLE_W-1:0]  diff_c;
  logic [ANGLE_W-1:0]  rem_c;

  // Stage 4: folded angle in 0..90 and final sign.
  logic                v4;
  logic                sign4;
  logic [FOLD_W-1:0]   x4;
  logic                hneg_c;
  logic [REM_W-1:0]    half_c;
  logic [REM_W-1:0]    fold_c;

  // Stage 5: output register.
  logic [MAG_W-1:0]    lut [0:QUARTER_TURN];
  logic [VALUE_W-1:0]  mag_c;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  always_comb begin
    sum_c = SUM_W'(angle_degrees) + (command ? SUM_W'(QUARTER_TURN) : SUM_W'(0));
    abs_c = sum_c[SUM_W-1] ? SUM_W'(-sum_c) : SUM_W'(sum_c);
  end

  assign prod_c = PROD_W'(mag1[ANGLE_W-1:3]) * PROD_W'(RECIP_45);

  always_comb begin
    diff_c = mag2 - (ANGLE_W'(q2) * ANGLE_W'(FULL_TURN));
    rem_c  = (diff_c >= ANGLE_W'(FULL_TURN)) ? diff_c - ANGLE_W'(FULL_TURN) : diff_c;
  end

  always_comb begin
    hneg_c = (r3 > REM_W'(HALF_TURN));
    half_c = hneg_c ? r3 - REM_W'(HALF_TURN) : r3;
    fold_c = (half_c > REM_W'(QUARTER_TURN)) ? REM_W'(HALF_TURN) - half_c : half_c;
  end

  for (genvar gi = 0; gi <= QUARTER_TURN; gi++) begin : g_lut
    assign lut[gi] = sine_q(gi);
  end

  assign mag_c = VALUE_W'(lut[x4]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      neg1       <= sum_c[SUM_W-1];
      mag1       <= abs_c[ANGLE_W-1:0];
      neg2       <= neg1;
      mag2       <= mag1;
      q2         <= prod_c[RECIP_SHIFT +: QUOT_W];
      neg3       <= neg2;
      r3         <= rem_c[REM_W-1:0];
      sign4      <= neg3 ^ hneg_c;
      x4         <= fold_c[FOLD_W-1:0];
      trig_value <= sign4 ? -$signed(mag_c) : $signed(mag_c);
    end
  end

`ifndef ASSERT_OFF
  a_rem_range : assert property (@(posedge clk) disable iff (rst)
    v3 |-> (r3 < REM_W'(FULL_TURN)))
    else $error("remainder out of range after correction");

  a_fold_range : assert property (@(posedge clk) disable iff (rst)
    v4 |-> (x4 <= FOLD_W'(QUARTER_TURN)))
    else $error("folded angle exceeds a quarter turn");

  a_quot_range : assert property (@(posedge clk) disable iff (rst)
    v2 |-> (ANGLE_W'(q2) * ANGLE_W'(FULL_TURN) <= mag2))
    else $error("quotient estimate too large");

  a_out_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((trig_value <= VALUE_W'(MAX_VALUE)) &&
                   (trig_value >= -VALUE_W'(MAX_VALUE))))
    else $error("result outside -9999..9999");

  a_advance : assert property (@(posedge clk) disable iff (rst)
    (v4 && advance) |=> out_valid)
    else $error("valid item lost between fold and output stages");
`endif

endmodule

@@ tb/tb_integer_degree_sine_cosine.sv @@
// Testbench for the integer-degree sine and cosine unit, with a self-checking predictor.
`timescale 1ns / 1ps

module tb_integer_degree_sine_cosine
  import idsc_pkg::*;
();

  localparam logic CMD_SINE   = 1'b0;
  localparam logic CMD_COSINE = 1'b1;
  localparam int   IDLE_PCT   = 12;
  localparam int   STALL_LIMIT = 2000;
  localparam int   DRAIN_CYCLES = 12;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      command = CMD_SINE;
  logic signed [ANGLE_W-1:0] angle_degrees = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] trig_value;

  logic signed [VALUE_W-1:0] expected_trig_q [$];
  int                        error_count = 0;
  int                        quiet_cycles = 0;
  bit                        no_idling = 1'b0;

  integer_degree_sine_cosine i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .angle_degrees (angle_degrees),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .trig_value    (trig_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sine of a whole-degree angle in ten-thousandths; cosine shifts the angle by a quarter turn
  // at full width before folding.
  function automatic logic signed [VALUE_W-1:0] predict_trig_value(
    input logic cmd, input logic signed [ANGLE_W-1:0] ang);
    longint deg;
    longint folded;
    longint poly;
    bit     negate;
    deg = longint'(ang);
    if (cmd == CMD_COSINE) deg = deg + 90;
    negate = (deg < 0);
    if (negate) deg = -deg;
    folded = deg % 360;
    if (folded > 180) begin
      negate = !negate;
      folded = folded - 180;
    end
    if (folded > 90) folded = 180 - folded;
    if (folded <= 45) begin
      poly = -81;
      poly = poly * folded - 277;
      poly = poly * folded + 1747900;
      poly = poly * folded - 1600;
      poly = poly / 10000;
    end else begin
      folded = 90 - folded;
      poly = 336;
      poly = poly * folded - 161420;
      poly = poly * folded + 75484;
      poly = poly * folded + 999960000;
      poly = poly / 100000;
    end
    if (negate) poly = -poly;
    return poly[VALUE_W-1:0];
  endfunction

  function automatic logic signed [ANGLE_W-1:0] random_angle();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return ANGLE_W'($urandom);
    if (pick < 60) return ANGLE_W'($urandom_range(32767, 32600));
    if (pick < 70) return ANGLE_W'(-$urandom_range(32768, 32600));
    return ANGLE_W'(int'($urandom_range(1440)) - 720);
  endfunction

  // Record the expected value of every input beat as it is taken.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected_trig_q.push_back(predict_trig_value(command, angle_degrees));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_trig_q.size() == 0) begin
        $error("trig_value: output beat %0d with no input pending", trig_value);
        error_count++;
      end else begin
        if (trig_value !== expected_trig_q[0]) begin
          $error("trig_value mismatch: expected %0d, actual %0d", expected_trig_q[0],
                 trig_value);
          error_count++;
        end
        void'(expected_trig_q.pop_front());
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !no_idling && ($urandom_range(99) < IDLE_PCT);
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic cmd, input logic signed [ANGLE_W-1:0] ang);
    if (!no_idling && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    angle_degrees <= ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed_angles();
    int edge_angle [12] = '{0, 45, 46, 90, 135, 181, 270, 359, 360, -1, -32768, 32767};
    for (int i = 0; i < 12; i++) begin
      send_beat(CMD_SINE, ANGLE_W'(edge_angle[i]));
      send_beat(CMD_COSINE, ANGLE_W'(edge_angle[i]));
    end
  endtask

  task automatic test_random_angles(input int count);
    for (int i = 0; i < count; i++) begin
      send_beat(logic'($urandom_range(1)), random_angle());
    end
  endtask

  // Full-rate stream with both sides always ready.
  task automatic test_unbroken_stream(input int count);
    no_idling = 1'b1;
    test_random_angles(count);
    no_idling = 1'b0;
  endtask

  // Short bursts, each followed by a pause until every result is back.
  task automatic test_drain_pauses(input int bursts);
    for (int b = 0; b < bursts; b++) begin
      test_random_angles($urandom_range(8, 1));
      in_valid <= 1'b0;
      while (expected_trig_q.size() != 0) @(negedge clk);
      @(negedge clk);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_angles();
    test_random_angles(350);
    test_unbroken_stream(150);
    test_drain_pauses(12);
    test_random_angles(250);

    in_valid <= 1'b0;
    while (expected_trig_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_trig_q.size() != 0) begin
      $error("trig_value: %0d results never arrived", expected_trig_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
